// ----- hw/rtl/cordic_sine_cosine_unit_defines.svh -----
// ----------------------------------------------------------------------------
// CORDIC sine/cosine unit assertion macros
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CORDIC_SINE_COSINE_UNIT_DEFINES_SVH
`define CORDIC_SINE_COSINE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CSC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define CSC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CSC_ASSERT(name, clk, rst_n, prop, msg)
`define CSC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/csc_pkg.sv -----
// ----------------------------------------------------------------------------
// CORDIC sine/cosine package
// Widths, constants, arctangent table and the data word passed between cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csc_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STEPS   = 31;
  localparam int unsigned STAGE_W = $clog2(STEPS);

  localparam logic signed [DATA_W-1:0] GAIN_Q31 = 32'sh4dba76d4;
  localparam logic signed [DATA_W-1:0] POS_FULL = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] NEG_FULL = 32'sh80000000;

  typedef enum logic [1:0] {
    KIND_ROT,
    KIND_ZERO,
    KIND_POS,
    KIND_NEG
  } csc_kind_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    csc_kind_e                kind;
  } csc_data_t;

  // atan(2^-i) / (pi/2), Q31
  function automatic logic signed [DATA_W-1:0] arc_atan(input logic [STAGE_W-1:0] idx);
    logic signed [DATA_W-1:0] r;
    unique case (idx)
      5'd0:    r = 32'sh40000000;
      5'd1:    r = 32'sh25c80a3b;
      5'd2:    r = 32'sh13f670b6;
      5'd3:    r = 32'sh0a2223a8;
      5'd4:    r = 32'sh05161a86;
      5'd5:    r = 32'sh028bafc2;
      5'd6:    r = 32'sh0145ec3c;
      5'd7:    r = 32'sh00a2f8aa;
      5'd8:    r = 32'sh00517ca6;
      5'd9:    r = 32'sh0028be5d;
      5'd10:   r = 32'sh00145f30;
      5'd11:   r = 32'sh000a2f98;
      5'd12:   r = 32'sh000517cc;
      5'd13:   r = 32'sh00028be6;
      5'd14:   r = 32'sh000145f3;
      5'd15:   r = 32'sh0000a2f9;
      5'd16:   r = 32'sh0000517c;
      5'd17:   r = 32'sh000028be;
      5'd18:   r = 32'sh0000145f;
      5'd19:   r = 32'sh00000a2f;
      5'd20:   r = 32'sh00000517;
      5'd21:   r = 32'sh0000028b;
      5'd22:   r = 32'sh00000145;
      5'd23:   r = 32'sh000000a2;
      5'd24:   r = 32'sh00000051;
      5'd25:   r = 32'sh00000028;
      5'd26:   r = 32'sh00000014;
      5'd27:   r = 32'sh0000000a;
      5'd28:   r = 32'sh00000005;
      5'd29:   r = 32'sh00000002;
      5'd30:   r = 32'sh00000001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/csc_cell.sv -----
// ----------------------------------------------------------------------------
// CORDIC micro-rotation cell
// One rotation-mode step with its own register and valid/ready handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "cordic_sine_cosine_unit_defines.svh"

module csc_cell
  import csc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [STAGE_W-1:0] stage_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire csc_data_t          in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output csc_data_t               out_data_o
);

  logic                     valid_q;
  csc_data_t                data_q, data_d;
  logic signed [DATA_W-1:0] dx, dy, da;

  assign in_ready_o = ~valid_q | out_ready_i;

  always_comb begin
    dx     = in_data_i.y >>> stage_i;
    dy     = in_data_i.x >>> stage_i;
    da     = arc_atan(stage_i);
    data_d = in_data_i;
    if (!in_data_i.z[DATA_W-1]) begin
      data_d.x = in_data_i.x - dx;
      data_d.y = in_data_i.y + dy;
      data_d.z = in_data_i.z - da;
    end else begin
      data_d.x = in_data_i.x + dx;
      data_d.y = in_data_i.y - dy;
      data_d.z = in_data_i.z + da;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  `CSC_ASSERT_NEXT(a_cell_hold, clk_i, rst_ni, valid_q && !out_ready_i,
                   valid_q && $stable(data_q), "cell lost or changed a stalled transaction")
  `CSC_ASSERT_NEXT(a_cell_take, clk_i, rst_ni, in_valid_i && in_ready_o,
                   valid_q, "cell dropped an accepted transaction")

endmodule

`default_nettype wire

// ----- hw/rtl/csc_out.sv -----
// ----------------------------------------------------------------------------
// CORDIC output stage
// Resolves the exact-angle cases and holds the result for the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csc_out
  import csc_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire csc_data_t                in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [DATA_W-1:0]      sine_o,
  output logic signed [DATA_W-1:0]      cosine_o
);

  logic                     valid_q;
  logic signed [DATA_W-1:0] sine_q, sine_d, cosine_q, cosine_d;

  assign in_ready_o = ~valid_q | out_ready_i;

  always_comb begin
    unique case (in_data_i.kind)
      KIND_ZERO: begin
        sine_d   = '0;
        cosine_d = POS_FULL;
      end
      KIND_POS: begin
        sine_d   = POS_FULL;
        cosine_d = '0;
      end
      KIND_NEG: begin
        sine_d   = NEG_FULL;
        cosine_d = '0;
      end
      default: begin
        sine_d   = in_data_i.y;
        cosine_d = in_data_i.x;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sine_q   <= sine_d;
      cosine_q <= cosine_d;
    end
  end

  assign out_valid_o = valid_q;
  assign sine_o      = sine_q;
  assign cosine_o    = cosine_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cordic_sine_cosine_unit.sv -----
// ----------------------------------------------------------------------------
// CORDIC sine/cosine unit
// Pipelined rotation-mode CORDIC, one angle per cycle while in_ready_o is high.
//
// Input channel: in_valid_i/in_ready_o with angle_i, a signed Q31 angle
// where -1..1 maps to -pi/2..pi/2. Output channel: out_valid_o/out_ready_i
// with sine_o and cosine_o, both signed Q31.
// Angle 0, the maximum and the minimum angle are flagged at entry and
// resolved exactly in the output stage; all others run the full rotation.
// A transaction passes through 31 rotation cells and then the output
// register; the depth of the cell chain is set by STEPS.
// Throughput: one transaction per cycle while in_ready_o is high; each cell and the output stage
// hold their own valid bit, so empty slots absorb stalls.
// When the receiver stalls, transactions pack up behind the output
// register and in_ready_o drops only once every stage is full.
// Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "cordic_sine_cosine_unit_defines.svh"

module cordic_sine_cosine_unit
  import csc_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [DATA_W-1:0] angle_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [DATA_W-1:0]      sine_o,
  output logic signed [DATA_W-1:0]      cosine_o
);

  logic      valid [STEPS+1];
  logic      ready [STEPS+1];
  csc_data_t data  [STEPS+1];

  always_comb begin
    data[0].x = GAIN_Q31;
    data[0].y = '0;
    data[0].z = angle_i;
    if (angle_i == '0) begin
      data[0].kind = KIND_ZERO;
    end else if (angle_i == POS_FULL) begin
      data[0].kind = KIND_POS;
    end else if (angle_i == NEG_FULL) begin
      data[0].kind = KIND_NEG;
    end else begin
      data[0].kind = KIND_ROT;
    end
  end

  assign valid[0]   = in_valid_i;
  assign in_ready_o = ready[0];

  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    csc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .stage_i     (STAGE_W'(k)),
      .in_valid_i  (valid[k]),
      .in_ready_o  (ready[k]),
      .in_data_i   (data[k]),
      .out_valid_o (valid[k+1]),
      .out_ready_i (ready[k+1]),
      .out_data_o  (data[k+1])
    );
  end

  csc_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid[STEPS]),
    .in_ready_o  (ready[STEPS]),
    .in_data_i   (data[STEPS]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sine_o      (sine_o),
    .cosine_o    (cosine_o)
  );

  `CSC_ASSERT(a_top_backpressure, clk_i, rst_ni, !in_ready_o |-> out_valid_o && !out_ready_i,
              "input stalled while the output side is free")

endmodule

`default_nettype wire
